// File: rtl/sha1_pkg.sv
// sha1_pkg: shared types, constants and state codes of the SHA-1 engine.
// No dependencies. Every other file in rtl imports it.
package sha1_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } hv_t;

  localparam int unsigned RND_W    = 7;
  localparam int unsigned NUM_H    = 5;
  localparam int unsigned BLK_WRDS = 16;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(79);
  localparam logic [RND_W-1:0] RND_K1   = RND_W'(20);
  localparam logic [RND_W-1:0] RND_K2   = RND_W'(40);
  localparam logic [RND_W-1:0] RND_K3   = RND_W'(60);

  localparam word_t H_INIT [NUM_H] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [2:0] IDX_LAST = 3'd4;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [RND_W-1:0] rnd;
  } rnd_ctl_t;

  typedef enum logic [1:0] {
    KIND_FULL,
    KIND_PAD,
    KIND_LEN
  } blk_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/sha1_msg.sv
// sha1_msg: 64-byte block store and 16-word rolling message schedule.
// Builds padded blocks on load. Depends on sha1_pkg.
module sha1_msg import sha1_pkg::*; (
  input  logic       clk,
  input  rnd_ctl_t   ctl,
  input  logic       wr_en,
  input  logic [5:0] wr_pos,
  input  logic [7:0] wr_byte,
  input  blk_kind_t  kind,
  input  logic [5:0] fill,
  input  logic [63:0] bit_len,
  output word_t      w
);

  word_t      blk_r [BLK_WRDS];
  word_t      sh_r  [BLK_WRDS];
  word_t      sh_nxt [BLK_WRDS];
  word_t      ld_w  [BLK_WRDS];
  logic [7:0] pb    [64];
  word_t      x;
  logic       len_on;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_r[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_comb begin
    len_on = (kind == KIND_LEN) || ((kind == KIND_PAD) && (fill < LEN_POS));
    for (int p = 0; p < 64; p++) begin
      case (kind)
        KIND_FULL: pb[p] = blk_r[p >> 2][8 * (3 - (p & 3)) +: 8];
        KIND_PAD: begin
          if (6'(p) < fill) begin
            pb[p] = blk_r[p >> 2][8 * (3 - (p & 3)) +: 8];
          end else if (6'(p) == fill) begin
            pb[p] = PAD_BYTE;
          end else begin
            pb[p] = 8'h00;
          end
        end
        default: pb[p] = 8'h00;
      endcase
    end
    if (len_on) begin
      for (int q = 0; q < 8; q++) begin
        pb[56 + q] = bit_len[8 * (7 - q) +: 8];
      end
    end
    for (int i = 0; i < BLK_WRDS; i++) begin
      ld_w[i] = {pb[4 * i], pb[4 * i + 1], pb[4 * i + 2], pb[4 * i + 3]};
    end
  end

  always_comb begin
    x = sh_r[13] ^ sh_r[8] ^ sh_r[2] ^ sh_r[0];
    for (int i = 0; i < BLK_WRDS; i++) begin
      sh_nxt[i] = sh_r[i];
    end
    if (ctl.load) begin
      for (int i = 0; i < BLK_WRDS; i++) begin
        sh_nxt[i] = ld_w[i];
      end
    end else if (ctl.step) begin
      for (int i = 0; i < BLK_WRDS - 1; i++) begin
        sh_nxt[i] = sh_r[i + 1];
      end
      sh_nxt[BLK_WRDS - 1] = {x[30:0], x[31]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BLK_WRDS; i++) begin
      sh_r[i] <= sh_nxt[i];
    end
  end

  assign w = sh_r[0];

endmodule

// File: rtl/sha1_round.sv
// sha1_round: the shared SHA-1 round unit, one round per clock.
// Holds the a..e working registers. Depends on sha1_pkg.
module sha1_round import sha1_pkg::*; (
  input  logic     clk,
  input  rnd_ctl_t ctl,
  input  hv_t      init,
  input  word_t    w,
  output hv_t      st
);

  hv_t   st_r;
  hv_t   st_nxt;
  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    if (ctl.rnd < RND_K1) begin
      f = st_r.d ^ (st_r.b & (st_r.c ^ st_r.d));
      k = K0;
    end else if (ctl.rnd < RND_K2) begin
      f = st_r.b ^ st_r.c ^ st_r.d;
      k = K1;
    end else if (ctl.rnd < RND_K3) begin
      f = (st_r.b & st_r.c) | (st_r.d & (st_r.b | st_r.c));
      k = K2;
    end else begin
      f = st_r.b ^ st_r.c ^ st_r.d;
      k = K3;
    end
    t = {st_r.a[26:0], st_r.a[31:27]} + f + st_r.e + k + w;
  end

  always_comb begin
    st_nxt = st_r;
    if (ctl.load) begin
      st_nxt = init;
    end else if (ctl.step) begin
      st_nxt.a = t;
      st_nxt.b = st_r.a;
      st_nxt.c = {st_r.b[1:0], st_r.b[31:2]};
      st_nxt.d = st_r.c;
      st_nxt.e = st_r.d;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st = st_r;

endmodule

// File: rtl/sha1_hash_engine.sv
// sha1_hash_engine: top level, sequencer, chain words and byte count.
// Instantiates sha1_msg and sha1_round. Depends on sha1_pkg.
//
// Byte-stream SHA-1. Each input word carries at most one message byte; a byte
// that does not complete a 64-byte block is taken and the block is ready for
// the next word right after. The byte that completes a block starts one
// compression: a load, all 80 rounds in the single round unit and a fold of
// the result into the chain, and the next word is taken after the fold. A last
// word adds one padded block, or two when 56 or more bytes sit in the block,
// then puts out five digest words, H0 first, one per cycle while out_stall is
// low. in_stall stays high from the start of a compression until the engine is
// idle again: after the fold, or after the last digest word is taken. The
// stored chain and count survive a digest, so hashing may go on afterwards.
module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_first_item,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  state_t           state_r, state_nxt;
  blk_kind_t        kind_r, kind_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic [RND_W-1:0] rnd_r;
  logic [2:0]       idx_r;
  logic [63:0]      cnt_r;
  logic [63:0]      cnt_base;
  word_t            chain_r  [NUM_H];
  word_t            work_h_r [NUM_H];
  word_t            sum_w    [NUM_H];
  word_t            base_w   [NUM_H];
  hv_t              base_hv;
  hv_t              st;
  word_t            w;
  rnd_ctl_t         ctl;
  logic             in_acc;
  logic             out_acc;
  logic             wr_en;
  logic             blk_full;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cnt_base = in_first_item ? 64'd0 : cnt_r;
  assign blk_full = in_has_byte && (cnt_base[5:0] == 6'd63);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pend_last_nxt = pend_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_full) begin
            state_nxt     = ST_LOAD;
            kind_nxt      = KIND_FULL;
            pend_last_nxt = in_last_item;
          end else if (in_last_item) begin
            state_nxt = ST_LOAD;
            kind_nxt  = KIND_PAD;
          end
        end
      end
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        unique case (kind_r)
          KIND_FULL: begin
            if (pend_last_r) begin
              state_nxt = ST_LOAD;
              kind_nxt  = KIND_PAD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          KIND_PAD: begin
            if (cnt_r[5:0] >= LEN_POS) begin
              state_nxt = ST_LOAD;
              kind_nxt  = KIND_LEN;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (out_acc && (idx_r == IDX_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    ctl.load  = (state_r == ST_LOAD);
    ctl.step  = (state_r == ST_ROUND);
    ctl.rnd   = rnd_r;
    wr_en     = in_acc && in_has_byte;
  end

  always_comb begin
    for (int i = 0; i < NUM_H; i++) begin
      base_w[i] = (kind_r == KIND_LEN) ? work_h_r[i] : chain_r[i];
    end
    base_hv = {base_w[0], base_w[1], base_w[2], base_w[3], base_w[4]};
    sum_w[0] = work_h_r[0] + st.a;
    sum_w[1] = work_h_r[1] + st.b;
    sum_w[2] = work_h_r[2] + st.c;
    sum_w[3] = work_h_r[3] + st.d;
    sum_w[4] = work_h_r[4] + st.e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_FULL;
      pend_last_r <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < NUM_H; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      pend_last_r <= pend_last_nxt;
      if (ctl.load) begin
        rnd_r <= '0;
      end else if (ctl.step) begin
        rnd_r <= rnd_r + RND_W'(1);
      end
      if (state_r == ST_ADD) begin
        idx_r <= '0;
      end else if (out_acc) begin
        idx_r <= idx_r + 3'd1;
      end
      if (in_acc) begin
        cnt_r <= in_has_byte ? cnt_base + 64'd1 : cnt_base;
        if (in_first_item) begin
          for (int i = 0; i < NUM_H; i++) begin
            chain_r[i] <= H_INIT[i];
          end
        end
      end
      if ((state_r == ST_ADD) && (kind_r == KIND_FULL)) begin
        for (int i = 0; i < NUM_H; i++) begin
          chain_r[i] <= sum_w[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < NUM_H; i++) begin
        work_h_r[i] <= base_w[i];
      end
    end else if (state_r == ST_ADD) begin
      for (int i = 0; i < NUM_H; i++) begin
        work_h_r[i] <= sum_w[i];
      end
    end
  end

  sha1_msg u_msg (
    .clk     (clk),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_pos  (cnt_base[5:0]),
    .wr_byte (in_data_byte),
    .kind    (kind_r),
    .fill    (cnt_r[5:0]),
    .bit_len ({cnt_r[60:0], 3'b000}),
    .w       (w)
  );

  sha1_round u_round (
    .clk  (clk),
    .ctl  (ctl),
    .init (base_hv),
    .w    (w),
    .st   (st)
  );

  assign out_digest_word = work_h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_final_word  = (idx_r == IDX_LAST);

endmodule

// File: rtl/sha1_checker.sv
// sha1_checker: port-level checks on the SHA-1 engine's handshakes.
// Bound to sha1_hash_engine below. Depends on sha1_pkg.
module sha1_checker import sha1_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_final_word
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("stalled digest word changed");

  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest goes out");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_final_word |=>
      out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest word index out of sequence");

  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_word == (out_word_index == IDX_LAST)))
    else $error("final flag not on word four");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_item |=> !out_valid)
    else $error("digest without last word");

endmodule

bind sha1_hash_engine sha1_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_item    (in_last_item),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_final_word  (out_final_word)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for sha1_hash_engine, byte-stream SHA-1 with a five-word digest.
// Predicts digests with its own SHA-1 model or a known value; uses types and constants from sha1_pkg.
module testbench;
  import sha1_pkg::*;

  localparam int HOLD_CYCLES = 600;
  localparam int RAND_WORDS  = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_out_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         has_byte;
    logic         first_item;
    logic         last_item;
    logic         known;
    logic [159:0] known_digest;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_first_item;
  logic        in_last_item;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;

  logic [159:0] chain_h;
  logic [511:0] msg_block;
  logic [63:0]  msg_len;
  digest_out_t  digest_q [$];
  int           mismatches = 0;
  bit           idle_on = 1'b1;
  bit           hold_off_req = 1'b0;

  stim_row_t dir_rows [19] = '{
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h61, 1'b1, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h64, 1'b1, 1'b0, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hff, 1'b1, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h5a, 1'b1, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'ha5, 1'b1, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'hff, 1'b1, 1'b0, 1'b1, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h7f, 1'b1, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 160'h0}
  };

  sha1_hash_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_first_item  (in_first_item),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_final_word (out_final_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [159:0] init_chain();
    logic [159:0] hv;
    for (int i = 0; i < NUM_H; i++) hv[159 - 32 * i -: 32] = H_INIT[i];
    return hv;
  endfunction

  function automatic logic [159:0] sha1_compress(input logic [159:0] hv, input logic [511:0] blk);
    word_t sched [16];
    word_t a, b, c, d, e, f, k, t, x;
    int s;
    for (int r = 0; r < 16; r++) sched[r] = blk[511 - 32 * r -: 32];
    {a, b, c, d, e} = hv;
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        x = sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^ sched[(s + 2) % 16] ^ sched[s];
        sched[s] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d));
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + sched[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
  endfunction

  function automatic void hash_item(input logic [7:0] data, input logic has, input logic first,
                                    input logic last, input logic known,
                                    input logic [159:0] known_digest);
    logic [159:0] hv;
    logic [511:0] pad;
    int fill;
    digest_out_t want;
    if (first) begin
      chain_h = init_chain();
      msg_len = '0;
    end
    if (has) begin
      msg_block[511 - 8 * int'(msg_len[5:0]) -: 8] = data;
      msg_len = msg_len + 64'd1;
      if (msg_len[5:0] == 6'd0) chain_h = sha1_compress(chain_h, msg_block);
    end
    if (last) begin
      fill = int'(msg_len[5:0]);
      pad = '0;
      for (int i = 0; i < fill; i++) pad[511 - 8 * i -: 8] = msg_block[511 - 8 * i -: 8];
      pad[511 - 8 * fill -: 8] = PAD_BYTE;
      hv = chain_h;
      if (fill >= int'(LEN_POS)) begin
        hv = sha1_compress(hv, pad);
        pad = '0;
      end
      pad[63:0] = msg_len << 3;
      hv = sha1_compress(hv, pad);
      if (known) hv = known_digest;
      for (int i = 0; i < NUM_H; i++) begin
        want.digest_word = hv[159 - 32 * i -: 32];
        want.word_index = 3'(i);
        want.final_word = (3'(i) == IDX_LAST);
        digest_q.push_back(want);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] data, input logic has, input logic first,
                           input logic last, input logic known, input logic [159:0] known_digest);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_has_byte   <= has;
    in_first_item <= first;
    in_last_item  <= last;
    do @(posedge clk); while (in_stall);
    hash_item(data, has, first, last, known, known_digest);
  endtask

  always @(posedge clk) begin : check_digest
    digest_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest word %h index %0d with none expected",
                                  out_digest_word, out_word_index));
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.digest_word)
          report_mismatch($sformatf("digest_word %h, want %h", out_digest_word, want.digest_word));
        if (out_word_index !== want.word_index)
          report_mismatch($sformatf("word_index %0d, want %0d", out_word_index, want.word_index));
        if (out_final_word !== want.final_word)
          report_mismatch($sformatf("final_word %b, want %b", out_final_word, want.final_word));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int rand_words;
    int len;
    int msg_no;
    bit restart;
    bit empty_last;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_has_byte   = 1'b0;
    in_first_item = 1'b0;
    in_last_item  = 1'b0;
    chain_h       = init_chain();
    msg_block     = '0;
    msg_len       = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].data_byte, dir_rows[i].has_byte, dir_rows[i].first_item,
                dir_rows[i].last_item, dir_rows[i].known, dir_rows[i].known_digest);

    rand_words = 0;
    msg_no = 0;
    while (rand_words < RAND_WORDS) begin
      if (msg_no == 2) hold_off_req = 1'b1;
      idle_on = (rand_words < RAND_WORDS - 40) && ($urandom_range(0, 3) != 0);
      restart = ($urandom_range(0, 7) != 0);
      if (msg_no == 0) len = 56 + $urandom_range(0, 7);
      else if (msg_no == 1) len = 64;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 12);
      empty_last = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 160'h0);
        send_word(8'($urandom), 1'b1, (restart && n == 0) || $urandom_range(0, 39) == 0,
                  !empty_last && n == len - 1, 1'b0, 160'h0);
        rand_words++;
      end
      if (empty_last) begin
        send_word(8'($urandom), 1'b0, restart && len == 0, 1'b1, 1'b0, 160'h0);
        rand_words++;
      end
      msg_no++;
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
